// ===== rtl/fpba_pkg.sv =====
// Shared types and constants for the fit-policy block allocator.
package fpba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } t_policy;

    typedef struct packed {
        logic        command;
        logic [3:0]  block_index;
        logic [15:0] size;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_block;
        logic [15:0] remaining_size;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic                  load_we;
        logic [IDX_W-1:0]      load_idx;
        logic [SIZE_WIDTH-1:0] load_size;
        logic                  start;
        logic [SIZE_WIDTH-1:0] req_size;
        logic [IDX_W-1:0]      rd_addr;
        logic                  chk;
        logic [IDX_W-1:0]      chk_idx;
        logic                  wb;
        logic [1:0]            policy;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== rtl/fpba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fpba_datapath.sv =====
// Allocator datapath: size table, used marks, candidate compare and result register.
module fpba_datapath import fpba_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic [SIZE_WIDTH-1:0] r_req;
    logic                  r_found;
    logic [IDX_W-1:0]      r_pick_idx;
    logic [SIZE_WIDTH-1:0] r_pick_size;
    logic [MAX_BLOCKS-1:0] r_used;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [SIZE_WIDTH-1:0] ram_wdata;
    logic [SIZE_WIDTH-1:0] rd_data;
    logic [SIZE_WIDTH-1:0] remain;
    logic                  fits;
    logic                  take;
    logic                  is_best;

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_data)
    );

    assign is_best = (i_cmd.policy == POL_BEST);
    assign remain  = r_pick_size - r_req;
    assign fits    = (rd_data >= r_req);

    always_comb begin
        take = 1'b0;
        case (i_cmd.policy)
            POL_FIRST: take = fits && !r_found;
            POL_BEST:  take = fits && !r_used[i_cmd.chk_idx]
                              && (!r_found || rd_data < r_pick_size);
            POL_WORST: take = fits && (!r_found || rd_data > r_pick_size);
            default:   take = 1'b0;
        endcase
    end

    // load writes and grant write-back never coincide
    always_comb begin
        if (i_cmd.load_we) begin
            ram_we    = 1'b1;
            ram_waddr = i_cmd.load_idx;
            ram_wdata = i_cmd.load_size;
        end else begin
            ram_we    = i_cmd.wb && r_found && !is_best;
            ram_waddr = r_pick_idx;
            ram_wdata = remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cmd.load_we) begin
                r_used[i_cmd.load_idx] <= 1'b0;
            end
            if (i_cmd.wb && r_found && is_best) begin
                r_used[r_pick_idx] <= 1'b1;
            end
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (i_cmd.chk && take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.wb) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req <= i_cmd.req_size;
        end
        if (i_cmd.chk && take) begin
            r_pick_idx  <= i_cmd.chk_idx;
            r_pick_size <= rd_data;
        end
        if (i_cmd.wb) begin
            r_out.granted <= r_found;
            if (r_found) begin
                r_out.chosen_block   <= 4'(r_pick_idx);
                r_out.remaining_size <= is_best ? 16'(r_pick_size) : 16'(remain);
            end else begin
                r_out.chosen_block   <= '0;
                r_out.remaining_size <= '0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ===== rtl/fpba_ctrl.sv =====
// Allocator controller: configuration registers and the scan sequencer.
module fpba_ctrl import fpba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output t_dp_cmd               o_cmd,
    input  t_dp_stat              i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WRITE
    } t_state;

    t_state           r_state;
    logic [1:0]       r_fit_policy;
    logic [4:0]       r_block_count;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_last;
    logic             r_chk;
    logic [IDX_W-1:0] r_chk_idx;

    logic             accept;
    logic [CNT_W-1:0] lim;
    logic             load_ok;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign load_ok = (32'(i_in_data.block_index) < 32'(MAX_BLOCKS));

    always_comb begin
        if (32'(r_block_count) > 32'(MAX_BLOCKS)) begin
            lim = CNT_W'(MAX_BLOCKS);
        end else begin
            lim = CNT_W'(r_block_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_fit_policy  <= '0;
            r_block_count <= '0;
            r_cnt         <= '0;
            r_last        <= '0;
            r_chk         <= 1'b0;
            r_chk_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIT_POLICY:  r_fit_policy  <= i_cfg_data[1:0];
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // read data for r_cnt shows up next cycle, checked under r_chk
            r_chk <= (r_state == S_SCAN);
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in_data.command == CMD_ALLOC) begin
                        r_cnt  <= '0;
                        r_last <= IDX_W'(lim - CNT_W'(1));
                        if (lim == '0 ||
                            !(r_fit_policy inside {POL_FIRST, POL_BEST, POL_WORST})) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk_idx <= r_cnt;
                    if (r_cnt == r_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (!i_stat.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_we   = accept && (i_in_data.command == CMD_LOAD) && load_ok;
        o_cmd.load_idx  = IDX_W'(i_in_data.block_index);
        o_cmd.load_size = SIZE_WIDTH'(i_in_data.size);
        o_cmd.start     = accept && (i_in_data.command == CMD_ALLOC);
        o_cmd.req_size  = SIZE_WIDTH'(i_in_data.size);
        o_cmd.rd_addr   = r_cnt;
        o_cmd.chk       = r_chk;
        o_cmd.chk_idx   = r_chk_idx;
        o_cmd.wb        = (r_state == S_WRITE) && !i_stat.out_busy;
        o_cmd.policy    = r_fit_policy;
    end

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// Fit-policy block allocator: first, best and worst fit over a table of free sizes.
// Load transfer: no result; next transfer accepted the cycle after.
// Allocate transfer: a scan of min(block_count,MAX_BLOCKS) entries (one table read per
// cycle from the size RAM), a drain, then a write-back that waits for a free output.
// Refused-by-config allocations (count 0, unused policy) skip the scan and go to write-back.
// Synchronous active-low reset clears used marks, config and control; table is unset.
module fit_policy_block_allocator import fpba_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fpba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    fpba_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.chk |-> !o_in_ready)
        else $error("input accepted while scan in flight");

    a_wb_needs_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.wb |-> !(o_out_valid && !i_out_ready))
        else $error("result write-back over an untaken result");

    a_wb_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.wb |=> o_out_valid)
        else $error("write-back did not raise output valid");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.granted) |->
            (o_out_data.chosen_block == '0 && o_out_data.remaining_size == '0))
        else $error("refused result carries nonzero fields");
`endif

endmodule

// ===== test/fit_policy_block_allocator_tb.sv =====
// Self-checking testbench for the fit-policy block allocator: directed table, then random phases.
module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    localparam logic [1:0] POL_UNUSED = 2'd3;
    localparam int NUM_PHASES = 13;
    localparam int PHASE_ITEMS = 100;
    localparam int SETTLE_CYCLES = 25;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_in_item   item;
        logic [1:0] pol;
        logic [4:0] cnt;
        bit         typed;
        t_out_item  want;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;

    // allocator state as the testbench sees it
    logic [SIZE_WIDTH-1:0] free_size [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] used_mark = '0;
    logic [MAX_BLOCKS-1:0] loaded = '0;
    logic [1:0]            cur_policy = POL_FIRST;
    logic [4:0]            cur_count = '0;

    t_out_item expected_grants[$];
    t_row      dir_rows[$];
    int        mismatches = 0;
    int        transfers_in = 0;
    bit        src_idle_en = 1'b1;
    bit        snk_idle_en = 1'b1;
    int        stall_left = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    fit_policy_block_allocator uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    // Returns 1 when the item produces a grant/refusal, with the predicted result.
    function automatic bit predict_grant(input t_in_item it, output t_out_item res);
        int lim;
        int pick;
        res = '0;
        if (it.command == CMD_LOAD) begin
            free_size[it.block_index] = it.size;
            used_mark[it.block_index] = 1'b0;
            loaded[it.block_index] = 1'b1;
            return 1'b0;
        end
        lim = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
        pick = -1;
        for (int k = 0; k < lim; k++) begin
            if (free_size[k] >= it.size) begin
                case (cur_policy)
                    POL_FIRST: begin
                        if (pick < 0) pick = k;
                    end
                    POL_BEST: begin
                        if (!used_mark[k] && (pick < 0 || free_size[k] < free_size[pick]))
                            pick = k;
                    end
                    POL_WORST: begin
                        if (pick < 0 || free_size[k] > free_size[pick]) pick = k;
                    end
                    default: ;
                endcase
            end
        end
        if (pick >= 0) begin
            if (cur_policy == POL_BEST)
                used_mark[pick] = 1'b1;
            else
                free_size[pick] = free_size[pick] - it.size;
            res.granted = 1'b1;
            res.chosen_block = 4'(pick);
            res.remaining_size = free_size[pick];
        end
        return 1'b1;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int lim;
        int sel;
        lim = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
        sel = $urandom_range(0, 9);
        it.block_index = 4'($urandom_range(0, MAX_BLOCKS - 1));
        it.command = ($urandom_range(0, 9) < 3) ? CMD_LOAD : CMD_ALLOC;
        if (it.command == CMD_LOAD)
            it.size = (sel < 5) ? 16'($urandom_range(0, 255)) :
                      (sel < 8) ? 16'($urandom) : (sel == 8) ? 16'hFFFF : 16'h0000;
        else
            it.size = (sel < 6) ? 16'($urandom_range(0, 63)) :
                      (sel < 8) ? 16'($urandom) : (sel == 8) ? 16'hFFFF : 16'h0000;
        // never search an entry that has not been loaded yet
        if (it.command == CMD_ALLOC) begin
            for (int k = 0; k < lim; k++) begin
                if (!loaded[k]) begin
                    it.command = CMD_LOAD;
                    it.block_index = 4'(k);
                    it.size = 16'($urandom_range(0, 1023));
                    break;
                end
            end
        end
        return it;
    endfunction

    function automatic t_row ld(input int idx, input logic [15:0] sz);
        t_row r;
        r = '{kind: ROW_ITEM, default: '0};
        r.kind = ROW_ITEM;
        r.item.command = CMD_LOAD;
        r.item.block_index = 4'(idx);
        r.item.size = sz;
        return r;
    endfunction

    function automatic t_row al(input logic [15:0] sz);
        t_row r;
        r = '{kind: ROW_ITEM, default: '0};
        r.kind = ROW_ITEM;
        r.item.command = CMD_ALLOC;
        r.item.size = sz;
        return r;
    endfunction

    function automatic t_row alx(input logic [15:0] sz, input logic g, input int blk,
                                 input logic [15:0] rem);
        t_row r;
        r = al(sz);
        r.typed = 1'b1;
        r.want.granted = g;
        r.want.chosen_block = 4'(blk);
        r.want.remaining_size = rem;
        return r;
    endfunction

    function automatic t_row cf(input logic [1:0] pol, input logic [4:0] cnt);
        t_row r;
        r = '{kind: ROW_CFG, default: '0};
        r.kind = ROW_CFG;
        r.pol = pol;
        r.cnt = cnt;
        return r;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item res;
        @(negedge clk);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        transfers_in++;
        if (predict_grant(it, res))
            expected_grants.push_back(typed ? want : res);
    endtask

    // drop valid, wait for every result, then let loads finish
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_grants.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [1:0] pol, input logic [4:0] cnt);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = CFG_FIT_POLICY;
        cfg_data = CFG_DATA_W'(pol);
        @(negedge clk);
        cfg_idx = CFG_BLOCK_COUNT;
        cfg_data = cnt;
        @(negedge clk);
        cfg_we = 1'b0;
        cur_policy = pol;
        cur_count = cnt;
    endtask

    // receiver: short random stalls, one long hold-off to back up the input side
    always @(negedge clk) begin
        if (!hold_done && transfers_in >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            out_ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_ready = 1'b0;
            stall_left--;
        end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
            out_ready = 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            out_ready = 1'b1;
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_grants.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: granted=%0d block=%0d remaining=%0d",
                             out_data.granted, out_data.chosen_block, out_data.remaining_size);
                mismatches++;
            end else begin
                want = expected_grants.pop_front();
                if (out_data.granted !== want.granted ||
                    out_data.chosen_block !== want.chosen_block ||
                    out_data.remaining_size !== want.remaining_size) begin
                    if (mismatches < 10)
                        $display({"result mismatch: expected granted=%0d block=%0d ",
                                  "remaining=%0d, got granted=%0d block=%0d remaining=%0d"},
                                 want.granted, want.chosen_block, want.remaining_size,
                                 out_data.granted, out_data.chosen_block,
                                 out_data.remaining_size);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [1:0] pol_plan [NUM_PHASES];
        logic [4:0] cnt_plan [NUM_PHASES];
        pol_plan = '{POL_FIRST, POL_BEST, POL_WORST, POL_BEST, POL_UNUSED, POL_WORST, POL_FIRST,
                     POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST, POL_FIRST};
        cnt_plan = '{5'd16, 5'd31, 5'd1, 5'd8, 5'd16, 5'd0, 5'd17, 5'd12, 5'd16, 5'd31,
                     5'd3, 5'd16, 5'd16};

        // after reset: first fit, nothing searched
        dir_rows.push_back(alx(16'd5, 1'b0, 0, 16'd0));
        dir_rows.push_back(ld(0, 16'hFFFF));
        dir_rows.push_back(ld(1, 16'h0000));
        dir_rows.push_back(ld(2, 16'd100));
        dir_rows.push_back(ld(3, 16'd100));
        dir_rows.push_back(ld(15, 16'h8000));
        dir_rows.push_back(cf(POL_FIRST, 5'd4));
        dir_rows.push_back(alx(16'hFFFF, 1'b1, 0, 16'd0));
        dir_rows.push_back(alx(16'd0, 1'b1, 0, 16'd0));
        dir_rows.push_back(al(16'd50));
        dir_rows.push_back(al(16'h1234));
        dir_rows.push_back(cf(POL_BEST, 5'd4));
        dir_rows.push_back(al(16'd100));
        dir_rows.push_back(al(16'd100));
        dir_rows.push_back(al(16'd0));
        dir_rows.push_back(al(16'd0));
        dir_rows.push_back(ld(3, 16'd7));
        dir_rows.push_back(al(16'd5));
        dir_rows.push_back(cf(POL_WORST, 5'd4));
        dir_rows.push_back(al(16'd1));
        dir_rows.push_back(alx(16'hFFFF, 1'b0, 0, 16'd0));
        dir_rows.push_back(cf(POL_UNUSED, 5'd4));
        dir_rows.push_back(alx(16'd0, 1'b0, 0, 16'd0));
        dir_rows.push_back(cf(POL_FIRST, 5'd1));
        dir_rows.push_back(alx(16'd1, 1'b0, 0, 16'd0));

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                settle();
                set_config(dir_rows[i].pol, dir_rows[i].cnt);
            end else begin
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            set_config(pol_plan[p], cnt_plan[p]);
            // no idling in the last phases, and none in every fourth one
            src_idle_en = (p < NUM_PHASES - 2) && (p % 4 != 3);
            snk_idle_en = src_idle_en;
            repeat (PHASE_ITEMS) send_item(rand_item(), 1'b0, '0);
        end

        settle();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fpba_datapath.sv
rtl/fpba_ctrl.sv
rtl/fit_policy_block_allocator.sv
test/fit_policy_block_allocator_tb.sv
